/* src/dfr_pkg.sv */
// Shared types and constants for the display frame receiver.
// Used by dfr_parse, display_frame_receiver and the testbench; no other dependencies.
`timescale 1ns / 1ps

package dfr_pkg;

  // Frame layout.
  localparam int unsigned FrameLen = 12;
  localparam logic [3:0] PosAssist = 4'd3;
  localparam logic [3:0] PosSpeed = 4'd4;
  localparam logic [3:0] PosMotor = 4'd5;
  localparam logic [3:0] PosMode = 4'd6;
  localparam logic [3:0] PosCheck = 4'd7;
  localparam logic [3:0] PosCurrent = 4'd9;
  localparam logic [3:0] PosLast = 4'(FrameLen - 1);

  // Header bytes and check masks.
  localparam logic [7:0] Hdr0 = 8'd50;
  localparam logic [7:0] Hdr1 = 8'd14;
  localparam logic [7:0] ChkMaskA = 8'd10;
  localparam logic [7:0] ChkMaskB = 8'd5;
  localparam logic [7:0] ChkMaskC = 8'd9;
  localparam logic [7:0] ChkMaskD = 8'd2;
  localparam logic [5:0] SpeedBase = 6'd10;

  // Receiver state, one-hot.
  typedef enum logic [2:0] {
    ST_HUNT0 = 3'b001,
    ST_HUNT1 = 3'b010,
    ST_BODY  = 3'b100
  } hunt_state_t;

  // One decoded frame.
  typedef struct packed {
    logic       frame_ok;
    logic [2:0] assist_level;
    logic [7:0] motor_characteristic;
    logic [4:0] wheel_size_code;
    logic [5:0] max_speed;
    logic       speed_limit_mode;
    logic [3:0] max_current_code;
  } result_t;

endpackage

/* src/dfr_parse.sv */
// Header hunt, running XOR and field capture for one received word per step.
// Depends on dfr_pkg for the state type, frame constants and result struct.
`timescale 1ns / 1ps

module dfr_parse (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       data,
  output logic             done,
  output dfr_pkg::result_t result
);

  dfr_pkg::hunt_state_t state;
  dfr_pkg::hunt_state_t state_next;
  logic [3:0] byte_count;
  logic [3:0] byte_count_next;
  logic [7:0] run_xor;
  logic [7:0] b3;
  logic [7:0] b4;
  logic [7:0] b5;
  logic [7:0] b6;
  logic [7:0] b7;
  logic [7:0] b9;
  logic [7:0] final_xor;
  logic       check_ok;

  // Next state and count.
  always_comb begin
    state_next = state;
    byte_count_next = byte_count;
    done = 1'b0;
    case (state)
      dfr_pkg::ST_HUNT1: begin
        if (data == dfr_pkg::Hdr1) begin
          state_next = dfr_pkg::ST_BODY;
          byte_count_next = byte_count + 4'd1;
        end else begin
          state_next = dfr_pkg::ST_HUNT0;
          byte_count_next = 4'd0;
        end
      end
      dfr_pkg::ST_BODY: begin
        if (byte_count == dfr_pkg::PosLast) begin
          done = 1'b1;
          state_next = dfr_pkg::ST_HUNT0;
          byte_count_next = 4'd0;
        end else begin
          byte_count_next = byte_count + 4'd1;
        end
      end
      default: begin
        if (data == dfr_pkg::Hdr0) begin
          state_next = dfr_pkg::ST_HUNT1;
          byte_count_next = 4'd1;
        end else begin
          state_next = dfr_pkg::ST_HUNT0;
          byte_count_next = 4'd0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dfr_pkg::ST_HUNT0;
      byte_count <= 4'd0;
    end else if (step) begin
      state <= state_next;
      byte_count <= byte_count_next;
    end
  end

  // Running XOR of the body and capture of the decoded bytes.
  always_ff @(posedge clk) begin
    if (step) begin
      if (state == dfr_pkg::ST_HUNT1) begin
        run_xor <= dfr_pkg::Hdr0 ^ dfr_pkg::Hdr1;
      end else if (state == dfr_pkg::ST_BODY && byte_count != dfr_pkg::PosCheck) begin
        run_xor <= run_xor ^ data;
      end
      if (state == dfr_pkg::ST_BODY) begin
        if (byte_count == dfr_pkg::PosAssist) b3 <= data;
        if (byte_count == dfr_pkg::PosSpeed) b4 <= data;
        if (byte_count == dfr_pkg::PosMotor) b5 <= data;
        if (byte_count == dfr_pkg::PosMode) b6 <= data;
        if (byte_count == dfr_pkg::PosCheck) b7 <= data;
        if (byte_count == dfr_pkg::PosCurrent) b9 <= data;
      end
    end
  end

  // Frame check on the last word, then field decode.
  assign final_xor = run_xor ^ data;
  assign check_ok = ((final_xor ^ dfr_pkg::ChkMaskA) == b7) ||
                    ((final_xor ^ dfr_pkg::ChkMaskB) == b7) ||
                    ((final_xor ^ dfr_pkg::ChkMaskC) == b7) ||
                    ((final_xor ^ dfr_pkg::ChkMaskD) == b7);

  always_comb begin
    result = '0;
    if (check_ok) begin
      result.frame_ok = 1'b1;
      result.assist_level = b3[2:0];
      result.motor_characteristic = b5;
      result.wheel_size_code = {b4[2:0], b6[7:6]};
      result.max_speed = (dfr_pkg::SpeedBase + {1'b0, b4[7:3]}) | {b6[5], 5'd0};
      result.speed_limit_mode = b6[3];
      result.max_current_code = b9[3:0];
    end
  end

endmodule

/* src/display_frame_receiver.sv */
// Top level of the display frame receiver: input register, parser, result register.
// Depends on dfr_pkg and dfr_parse.
//
//   channel | handshake            | payload
//   rx      | rx_valid / rx_ready  | rx_byte
//   res     | res_valid / res_ready| frame_ok .. max_current_code
//
// One word is taken per cycle unless stalled; the parser handles it from the input
// register; a frame's result appears the cycle after its twelfth word is parsed.
// Throughput is set by the single parse step: one word per cycle unless stalled.
// Reset clears the hunt state, the byte count and both valid flags.
// A result that is not taken stalls the parser; one more word can wait in the
// input register, so rx_ready falls only when that register is also full.
`timescale 1ns / 1ps

module display_frame_receiver (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_ready,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  input  logic       res_ready,
  output logic       frame_ok,
  output logic [2:0] assist_level,
  output logic [7:0] motor_characteristic,
  output logic [4:0] wheel_size_code,
  output logic [5:0] max_speed,
  output logic       speed_limit_mode,
  output logic [3:0] max_current_code
);

  logic             held_valid;
  logic [7:0]       held_byte;
  logic             advance;
  logic             step;
  logic             done;
  dfr_pkg::result_t result_next;
  dfr_pkg::result_t result;

  // The parser moves when a word is held and the result register can take a new result.
  assign advance = !res_valid || res_ready;
  assign step = held_valid && advance;
  assign rx_ready = !held_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (rx_ready) begin
      held_valid <= rx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_ready && rx_valid) begin
      held_byte <= rx_byte;
    end
  end

  dfr_parse u_parse (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .data   (held_byte),
    .done   (done),
    .result (result_next)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= step && done;
    end
  end

  always_ff @(posedge clk) begin
    if (step && done) begin
      result <= result_next;
    end
  end

  assign frame_ok = result.frame_ok;
  assign assist_level = result.assist_level;
  assign motor_characteristic = result.motor_characteristic;
  assign wheel_size_code = result.wheel_size_code;
  assign max_speed = result.max_speed;
  assign speed_limit_mode = result.speed_limit_mode;
  assign max_current_code = result.max_current_code;

endmodule

/* tb/sv/tb_display_frame_receiver.sv */
// Self-checking testbench for display_frame_receiver: random and directed byte streams,
// a word-level predictor of the frame decoder and a field-by-field result check.
// Depends on dfr_pkg and the display_frame_receiver RTL.
`timescale 1ns / 1ps

module tb_display_frame_receiver;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned TailCycles = 20;
  localparam int unsigned WordTarget = 1350;
  localparam int unsigned HoldStartWord = 300;
  localparam int unsigned HoldCycles = 250;
  localparam int unsigned CalmFirstWord = 700;
  localparam int unsigned CalmLastWord = 900;
  localparam int unsigned IdlePercent = 26;

  // How the body bytes of a generated frame are filled.
  typedef enum int {
    BODY_RANDOM,
    BODY_ONES,
    BODY_EXTREME
  } body_style_t;

  // Which check byte a generated frame carries.
  typedef enum int {
    CHK_A,
    CHK_B,
    CHK_C,
    CHK_D,
    CHK_BAD
  } check_kind_t;

  // One entry of the stimulus stream: a word to send, or a pause marker.
  typedef struct {
    bit         pause;
    logic [7:0] data;
  } link_word_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       rx_valid = 1'b0;
  logic       rx_ready;
  logic [7:0] rx_byte = 8'h00;
  logic       res_valid;
  logic       res_ready = 1'b0;
  logic       frame_ok;
  logic [2:0] assist_level;
  logic [7:0] motor_characteristic;
  logic [4:0] wheel_size_code;
  logic [5:0] max_speed;
  logic       speed_limit_mode;
  logic [3:0] max_current_code;

  display_frame_receiver dut (
    .clk                  (clk),
    .rst                  (rst),
    .rx_valid             (rx_valid),
    .rx_ready             (rx_ready),
    .rx_byte              (rx_byte),
    .res_valid            (res_valid),
    .res_ready            (res_ready),
    .frame_ok             (frame_ok),
    .assist_level         (assist_level),
    .motor_characteristic (motor_characteristic),
    .wheel_size_code      (wheel_size_code),
    .max_speed            (max_speed),
    .speed_limit_mode     (speed_limit_mode),
    .max_current_code     (max_current_code)
  );

  always #10 clk = ~clk;

  // Stimulus stream, decoded frames still owed by the block, and run statistics.
  link_word_t         tx_words_q[$];
  dfr_pkg::result_t   frame_results_q[$];
  int unsigned        words_taken = 0;
  int unsigned        frame_words = 0;
  int unsigned        frames_passed = 0;
  int unsigned        frames_failed = 0;
  int unsigned        mismatches = 0;
  int unsigned        cycle_count = 0;
  bit                 rx_took = 1'b0;
  bit                 sender_pausing = 1'b0;
  int unsigned        settle_left = 0;
  int unsigned        hold_left = 0;
  bit                 hold_done = 1'b0;

  // Predictor state of the frame decoder.
  dfr_pkg::hunt_state_t hunt;
  logic [3:0]           word_count;
  logic [7:0]           frame_buf [dfr_pkg::FrameLen];
  dfr_pkg::result_t     got_result;
  dfr_pkg::result_t     new_result;

  wire calm = words_taken >= CalmFirstWord && words_taken < CalmLastWord;

  function automatic void store_word(input logic [7:0] b);
    if (word_count < dfr_pkg::FrameLen) begin
      frame_buf[word_count] = b;
    end
    word_count = word_count + 4'd1;
  endfunction

  // Advances the decoder by one received word; returns 1 when a frame completes.
  function automatic bit decode_word(input logic [7:0] b, output dfr_pkg::result_t r);
    logic [7:0] x;
    logic [7:0] chk;
    r = '0;
    decode_word = 1'b0;
    case (hunt)
      dfr_pkg::ST_HUNT1: begin
        if (b == dfr_pkg::Hdr1) begin
          store_word(b);
          hunt = dfr_pkg::ST_BODY;
        end else begin
          word_count = '0;
          hunt = dfr_pkg::ST_HUNT0;
        end
      end
      dfr_pkg::ST_BODY: begin
        store_word(b);
        if (word_count >= dfr_pkg::FrameLen) begin
          word_count = '0;
          hunt = dfr_pkg::ST_HUNT0;
          decode_word = 1'b1;
          x = '0;
          for (int i = 0; i < dfr_pkg::FrameLen; i++) begin
            if (i != dfr_pkg::PosCheck) x ^= frame_buf[i];
          end
          chk = frame_buf[dfr_pkg::PosCheck];
          if ((x ^ dfr_pkg::ChkMaskA) == chk || (x ^ dfr_pkg::ChkMaskB) == chk ||
              (x ^ dfr_pkg::ChkMaskC) == chk || (x ^ dfr_pkg::ChkMaskD) == chk) begin
            r.frame_ok = 1'b1;
            r.assist_level = frame_buf[dfr_pkg::PosAssist][2:0];
            r.motor_characteristic = frame_buf[dfr_pkg::PosMotor];
            r.wheel_size_code = {frame_buf[dfr_pkg::PosSpeed][2:0],
                                 frame_buf[dfr_pkg::PosMode][7:6]};
            r.max_speed = (dfr_pkg::SpeedBase + {1'b0, frame_buf[dfr_pkg::PosSpeed][7:3]}) |
                          {frame_buf[dfr_pkg::PosMode][5], 5'b0};
            r.speed_limit_mode = frame_buf[dfr_pkg::PosMode][3];
            r.max_current_code = frame_buf[dfr_pkg::PosCurrent][3:0];
          end
        end
      end
      default: begin
        word_count = '0;
        if (b == dfr_pkg::Hdr0) begin
          store_word(b);
          hunt = dfr_pkg::ST_HUNT1;
        end else begin
          hunt = dfr_pkg::ST_HUNT0;
        end
      end
    endcase
  endfunction

  function automatic void compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Monitor: checks results and feeds accepted words to the predictor.
  always @(posedge clk) begin
    if (rst) begin
      hunt = dfr_pkg::ST_HUNT0;
      word_count = '0;
      rx_took = 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        got_result = '{frame_ok, assist_level, motor_characteristic, wheel_size_code,
                       max_speed, speed_limit_mode, max_current_code};
        if (frame_results_q.size() == 0) begin
          $error("result word with no frame pending");
          mismatches++;
        end else begin
          new_result = frame_results_q.pop_front();
          compare_field("frame_ok", new_result.frame_ok, got_result.frame_ok);
          compare_field("assist_level", new_result.assist_level, got_result.assist_level);
          compare_field("motor_characteristic", new_result.motor_characteristic,
                        got_result.motor_characteristic);
          compare_field("wheel_size_code", new_result.wheel_size_code,
                        got_result.wheel_size_code);
          compare_field("max_speed", new_result.max_speed, got_result.max_speed);
          compare_field("speed_limit_mode", new_result.speed_limit_mode,
                        got_result.speed_limit_mode);
          compare_field("max_current_code", new_result.max_current_code,
                        got_result.max_current_code);
          if (new_result.frame_ok) frames_passed++;
          else frames_failed++;
        end
      end
      rx_took = rx_valid && rx_ready;
      if (rx_took) begin
        words_taken++;
        if (decode_word(rx_byte, new_result)) frame_results_q.push_back(new_result);
      end
    end
  end

  // Driver: holds a word until it is taken, idles at random and honors pause markers.
  always @(negedge clk) begin
    if (!rst && !(rx_valid && !rx_took)) begin
      if (settle_left != 0) begin
        rx_valid <= 1'b0;
        settle_left <= settle_left - 1;
      end else if (sender_pausing) begin
        rx_valid <= 1'b0;
        if (frame_results_q.size() == 0) begin
          sender_pausing <= 1'b0;
          settle_left <= SettleCycles;
        end
      end else if (tx_words_q.size() != 0 &&
                   (calm || $urandom_range(99) >= IdlePercent)) begin
        if (tx_words_q[0].pause) begin
          sender_pausing <= 1'b1;
          rx_valid <= 1'b0;
        end else begin
          rx_byte <= tx_words_q[0].data;
          rx_valid <= 1'b1;
        end
        void'(tx_words_q.pop_front());
      end else begin
        rx_valid <= 1'b0;
      end
    end
  end

  // Result side: random stalls, one long hold-off once the run is under way.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      res_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && words_taken >= HoldStartWord) begin
      hold_done <= 1'b1;
      hold_left <= HoldCycles;
      res_ready <= 1'b0;
    end else begin
      res_ready <= calm || $urandom_range(99) >= IdlePercent;
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic push_word(input logic [7:0] b);
    tx_words_q.push_back('{pause: 1'b0, data: b});
  endtask

  task automatic push_pause();
    tx_words_q.push_back('{pause: 1'b1, data: 8'h00});
  endtask

  // Queues one complete frame with the chosen body and check byte.
  task automatic queue_frame(input body_style_t style, input check_kind_t kind);
    logic [7:0] fb [dfr_pkg::FrameLen];
    logic [7:0] x;
    logic [7:0] m;
    x = '0;
    for (int i = 0; i < dfr_pkg::FrameLen; i++) begin
      case (style)
        BODY_ONES:    fb[i] = 8'hFF;
        BODY_EXTREME: fb[i] = $urandom_range(1) ? 8'hFF : 8'h00;
        default:      fb[i] = 8'($urandom);
      endcase
    end
    fb[0] = dfr_pkg::Hdr0;
    fb[1] = dfr_pkg::Hdr1;
    for (int i = 0; i < dfr_pkg::FrameLen; i++) begin
      if (i != dfr_pkg::PosCheck) x ^= fb[i];
    end
    case (kind)
      CHK_A: m = dfr_pkg::ChkMaskA;
      CHK_B: m = dfr_pkg::ChkMaskB;
      CHK_C: m = dfr_pkg::ChkMaskC;
      CHK_D: m = dfr_pkg::ChkMaskD;
      default: begin
        m = 8'($urandom);
        while (m == dfr_pkg::ChkMaskA || m == dfr_pkg::ChkMaskB ||
               m == dfr_pkg::ChkMaskC || m == dfr_pkg::ChkMaskD) begin
          m = 8'($urandom);
        end
      end
    endcase
    fb[dfr_pkg::PosCheck] = x ^ m;
    for (int i = 0; i < dfr_pkg::FrameLen; i++) push_word(fb[i]);
    frame_words += dfr_pkg::FrameLen;
  endtask

  initial begin
    int unsigned pick;
    int unsigned rounds;
    logic [7:0] b;

    // Directed part: noise while hunting, a second header byte that is wrong
    // (including a repeated first header byte), then frames with all-ones field
    // bytes that pass and fail the check.
    push_word(8'h00);
    push_word(8'hFF);
    push_word(dfr_pkg::Hdr0);
    push_word(dfr_pkg::Hdr0);
    push_word(dfr_pkg::Hdr0);
    push_word(8'h07);
    queue_frame(BODY_ONES, CHK_A);
    queue_frame(BODY_ONES, CHK_BAD);
    push_pause();

    // Random part: mostly well-formed frames, with noise and broken headers between.
    rounds = 0;
    while (tx_words_q.size() < WordTarget) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        queue_frame(pick < 12 ? BODY_EXTREME : BODY_RANDOM,
                    $urandom_range(9) == 0 ? CHK_BAD : check_kind_t'($urandom_range(3)));
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 4)) begin
          push_word($urandom_range(4) == 0 ? dfr_pkg::Hdr0 : 8'($urandom));
        end
      end else begin
        push_word(dfr_pkg::Hdr0);
        b = $urandom_range(2) == 0 ? dfr_pkg::Hdr0 : 8'($urandom);
        if (b == dfr_pkg::Hdr1) b = b + 8'd1;
        push_word(b);
      end
      rounds++;
      if (rounds % 40 == 0) push_pause();
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait until every word is taken and every frame result has come back.
    while (tx_words_q.size() != 0 || rx_valid || sender_pausing || settle_left != 0) begin
      @(posedge clk);
    end
    while (frame_results_q.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (frame_results_q.size() != 0) begin
      $error("%0d frame results never arrived", frame_results_q.size());
      mismatches++;
    end

    $display("Sent %0d words, %0d of them inside generated frames.",
             words_taken, frame_words);
    $display("Checked %0d decoded frames and %0d frames rejected by the check byte.",
             frames_passed, frames_failed);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
